@@ design/wehs_pkg.sv @@
// ----------------------------------------------------------------------------
// wehs_pkg
// Shared types and constants for the wall edge height splitter.
// ----------------------------------------------------------------------------
package wehs_pkg;

  localparam int unsigned DW              = 32;
  localparam int unsigned MAX_HEIGHTS_DEF = 16;
  localparam int unsigned RESULT_LIMIT    = 16;
  localparam int unsigned MIN_SPLIT       = 2;

  // divider: numerator is |du| or |dv| << 16, denominator is |dz|
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned DEN_W  = DW + 1;
  localparam int unsigned QW     = DEN_W + FRAC_W;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_INSERT  = 2'd1,
    FUNC_SPLIT_L = 2'd2,
    FUNC_SPLIT_R = 2'd3
  } func_e;

  typedef struct packed {
    logic             start;
    logic [QW-1:0]    num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

endpackage

@@ design/wehs_if.sv @@
// ----------------------------------------------------------------------------
// wehs_in_if / wehs_out_if
// Valid/ready channels carrying query beats and split vertex beats.
// ----------------------------------------------------------------------------
interface wehs_in_if import wehs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic signed [DW-1:0] new_height;
  logic signed [DW-1:0] z_bottom;
  logic signed [DW-1:0] z_top;
  logic signed [DW-1:0] u_top;
  logic signed [DW-1:0] v_top;
  logic signed [DW-1:0] u_bottom;
  logic signed [DW-1:0] v_bottom;
  logic signed [DW-1:0] z_ceil;
  logic signed [DW-1:0] z_floor;
  logic signed [DW-1:0] pos_x;
  logic signed [DW-1:0] pos_y;

  modport source (output valid, func, new_height, z_bottom, z_top, u_top, v_top,
                  u_bottom, v_bottom, z_ceil, z_floor, pos_x, pos_y,
                  input ready);
  modport sink   (input valid, func, new_height, z_bottom, z_top, u_top, v_top,
                  u_bottom, v_bottom, z_ceil, z_floor, pos_x, pos_y,
                  output ready);
endinterface

interface wehs_out_if import wehs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] split_height;
  logic signed [DW-1:0] tex_u;
  logic signed [DW-1:0] tex_v;
  logic signed [DW-1:0] ceil_dist;
  logic signed [DW-1:0] floor_dist;
  logic signed [DW-1:0] out_x;
  logic signed [DW-1:0] out_y;
  logic                 last;

  modport source (output valid, split_height, tex_u, tex_v, ceil_dist, floor_dist,
                  out_x, out_y, last, input ready);
  modport sink   (input valid, split_height, tex_u, tex_v, ceil_dist, floor_dist,
                  out_x, out_y, last, output ready);
endinterface

@@ design/wehs_ram.sv @@
// ----------------------------------------------------------------------------
// wehs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wehs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/wehs_div.sv @@
// ----------------------------------------------------------------------------
// wehs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wehs_div import wehs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DEN_W-1:0]   rem_q, den_q;
  logic [QW-1:0]      quo_q;
  logic [DEN_W:0]     trial;
  logic               ge;

  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
        rem_q  <= '0;
        quo_q  <= req_i.num;
        den_q  <= req_i.den;
      end else if (busy_q) begin
        rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
        quo_q <= {quo_q[QW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  property p_no_restart;
    @(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q;
  endproperty
  a_no_restart: assert property (p_no_restart)
    else $error("divider started while busy");

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) $rose(done_q) |-> $past(busy_q);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("divider done without a running division");

  property p_start_nonzero;
    @(posedge clk_i) disable iff (!rst_ni) req_i.start |-> req_i.den != '0;
  endproperty
  a_start_nonzero: assert property (p_start_nonzero)
    else $error("divider started with zero denominator");

endmodule

@@ design/wall_edge_height_splitter_unit.sv @@
// ----------------------------------------------------------------------------
// wall_edge_height_splitter_unit
// Sorted per-vertex height list; splits wall edges at stored heights.
// ----------------------------------------------------------------------------
// channel  port   dir  beat
// query    in_i   in   func, new_height, edge heights, tex coords, ceil/floor, pos
// vertex   out_o  out  split_height, tex_u, tex_v, ceil_dist, floor_dist, out_x/y, last
//
// Clear empties the list. Insert time grows with the count, set by the single RAM port.
// Split: 2 divisions on the shared divider (none for a flat edge), then a scan over
// the stored heights with a multiply pass per emitted vertex on the shared 25x33
// multiplier, and a close. Fewer than three heights: back to idle with no output.
// Async active-low reset empties the list; list contents are not cleared.
// in_i is ready only between queries; the output register stalls the scan when full.
// ----------------------------------------------------------------------------
module wall_edge_height_splitter_unit import wehs_pkg::*; #(
  parameter int unsigned MAX_HEIGHTS = MAX_HEIGHTS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  wehs_in_if.sink    in_i,
  wehs_out_if.source out_o
);

  localparam int unsigned IW   = $clog2(MAX_HEIGHTS);
  localparam int unsigned CW   = $clog2(MAX_HEIGHTS + 1);
  localparam int unsigned NW   = $clog2(RESULT_LIMIT + 1);
  localparam int unsigned FLO  = 25;
  localparam int unsigned MW   = FLO + DEN_W;
  localparam int unsigned AW   = 64;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_SH_RD, S_SH_WR, S_DIVS, S_DIVW,
    S_SC_RD, S_SC_CMP, S_M0, S_M1, S_M2, S_FIN
  } state_e;

  state_e state_q;

  logic [CW-1:0] count_q, i_q;
  logic [IW-1:0] k_q, j_q;
  logic [NW-1:0] n_q;
  logic          uv_q, st_v_q;

  logic [1:0]           func_q;
  logic signed [DW-1:0] nh_q, zb_q, zt_q, ut_q, vt_q, ub_q, vb_q, zc_q, zf_q, px_q, py_q;

  logic [QW-1:0]        fm_q [2];
  logic                 fs_q [2];
  logic [DEN_W-1:0]     offm_q;
  logic                 offs_q;
  logic [AW-1:0]        acc_q;
  logic signed [DW-1:0] st_h_q, st_tu_q, st_tv_q;

  logic                 out_v_q, out_last_q;
  logic signed [DW-1:0] o_h_q, o_tu_q, o_tv_q, o_cd_q, o_fd_q, o_x_q, o_y_q;

  logic                 ram_we, ram_re;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  logic [DW-1:0]        ram_wdata, ram_rdata;
  logic signed [DW-1:0] h;

  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic signed [DW-1:0] sat32(input logic signed [DW+2:0] v);
    logic signed [DW+2:0] hi, lo;
    hi = (DW+3)'($signed({1'b0, {(DW-1){1'b1}}}));
    lo = -hi - 1;
    if (v > hi) return {1'b0, {(DW-1){1'b1}}};
    if (v < lo) return {1'b1, {(DW-1){1'b0}}};
    return v[DW-1:0];
  endfunction

  // edge deltas
  logic signed [DW:0] dz, du, dv, dsel, off;
  assign dz   = $signed({zt_q[DW-1], zt_q}) - $signed({zb_q[DW-1], zb_q});
  assign du   = $signed({ut_q[DW-1], ut_q}) - $signed({ub_q[DW-1], ub_q});
  assign dv   = $signed({vt_q[DW-1], vt_q}) - $signed({vb_q[DW-1], vb_q});
  assign dsel = uv_q ? dv : du;

  logic [DEN_W-1:0] dz_mag, dsel_mag, off_mag;
  assign dz_mag   = dz[DW]   ? DEN_W'(-dz)   : DEN_W'(dz);
  assign dsel_mag = dsel[DW] ? DEN_W'(-dsel) : DEN_W'(dsel);

  assign h       = $signed(ram_rdata);
  assign off     = $signed({h[DW-1], h}) - $signed({zt_q[DW-1], zt_q});
  assign off_mag = off[DW] ? DEN_W'(-off) : DEN_W'(off);

  assign div_req.start = (state_q == S_DIVS) && (dz != '0);
  assign div_req.num   = {dsel_mag, {FRAC_W{1'b0}}};
  assign div_req.den   = dz_mag;

  // shared multiplier, low then high half of the factor
  logic [FLO-1:0] mul_a;
  logic [MW-1:0]  mul_p;
  assign mul_a = (state_q == S_M0) ? fm_q[uv_q][FLO-1:0] : FLO'(fm_q[uv_q][QW-1:FLO]);
  assign mul_p = MW'(mul_a) * MW'(offm_q);

  // finalize texture coordinate
  logic [DW:0]          prod_mag;
  logic signed [DW+1:0] delta;
  logic signed [DW+2:0] tex_sum;
  logic signed [DW-1:0] tex_top, tex_val;
  assign prod_mag = acc_q[FRAC_W +: DW+1];
  assign delta    = (fs_q[uv_q] ^ offs_q) ? -$signed({1'b0, prod_mag})
                                          :  $signed({1'b0, prod_mag});
  assign tex_top  = uv_q ? vt_q : ut_q;
  assign tex_sum  = (DW+3)'(tex_top) + (DW+3)'(delta);
  assign tex_val  = sat32(tex_sum);

  // scan decisions
  logic is_left, sc_skip, sc_emit, sc_end;
  assign is_left = (func_q == FUNC_SPLIT_L);
  assign sc_end  = is_left ? (i_q == count_q) : (i_q == '0);
  assign sc_skip = is_left ? (h <= zb_q) : (h >= zt_q);
  assign sc_emit = !sc_skip && (is_left ? (h < zt_q) : (h > zb_q));

  logic push_ok;
  assign push_ok = !out_v_q || out_o.ready;

  logic signed [DW+2:0] cd_sum, fd_sum;
  assign cd_sum = (DW+3)'(zc_q) - (DW+3)'(st_h_q);
  assign fd_sum = (DW+3)'(st_h_q) - (DW+3)'(zf_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = nh_q;
    case (state_q)
      S_INS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k_q;
      end
      S_SH_RD: begin
        if (j_q == k_q) begin
          ram_we    = 1'b1;
          ram_waddr = k_q;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_q - 1'b1;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = ram_rdata;
      end
      S_SC_RD: begin
        ram_re    = !sc_end;
        ram_raddr = i_q[IW-1:0];
      end
      default: ;
    endcase
  end

  wehs_ram #(.WIDTH(DW), .DEPTH(MAX_HEIGHTS)) u_list (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  wehs_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  logic in_acc, push, push_last;
  assign in_acc    = in_i.valid && in_i.ready;
  assign push      = push_ok && ((state_q == S_SC_CMP && sc_emit && st_v_q) ||
                                 (state_q == S_FIN && st_v_q));
  assign push_last = (state_q == S_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      i_q        <= '0;
      k_q        <= '0;
      j_q        <= '0;
      n_q        <= '0;
      uv_q       <= 1'b0;
      st_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (push) begin
        out_v_q    <= 1'b1;
        out_last_q <= push_last;
        o_h_q      <= st_h_q;
        o_tu_q     <= st_tu_q;
        o_tv_q     <= st_tv_q;
        o_cd_q     <= sat32(cd_sum);
        o_fd_q     <= sat32(fd_sum);
        o_x_q      <= px_q;
        o_y_q      <= py_q;
        st_v_q     <= 1'b0;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            func_q <= in_i.func;
            nh_q   <= in_i.new_height;
            zb_q   <= in_i.z_bottom;
            zt_q   <= in_i.z_top;
            ut_q   <= in_i.u_top;
            vt_q   <= in_i.v_top;
            ub_q   <= in_i.u_bottom;
            vb_q   <= in_i.v_bottom;
            zc_q   <= in_i.z_ceil;
            zf_q   <= in_i.z_floor;
            px_q   <= in_i.pos_x;
            py_q   <= in_i.pos_y;
            k_q    <= '0;
            n_q    <= '0;
            uv_q   <= 1'b0;
            i_q    <= (in_i.func == FUNC_SPLIT_L) ? '0 : count_q - 1'b1;
            case (in_i.func)
              FUNC_CLEAR:  count_q <= '0;
              FUNC_INSERT: begin
                if (count_q < CW'(MAX_HEIGHTS)) state_q <= S_INS_RD;
              end
              default: begin
                if (count_q > CW'(MIN_SPLIT)) state_q <= S_DIVS;
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (CW'(k_q) == count_q) begin
            j_q     <= k_q;
            state_q <= S_SH_RD;
          end else begin
            state_q <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (h < nh_q) begin
            k_q     <= k_q + 1'b1;
            state_q <= S_INS_RD;
          end else if (h == nh_q) begin
            state_q <= S_IDLE;
          end else begin
            j_q     <= count_q[IW-1:0];
            state_q <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          if (j_q == k_q) begin
            count_q <= count_q + 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          j_q     <= j_q - 1'b1;
          state_q <= S_SH_RD;
        end
        S_DIVS: begin
          if (dz == '0) begin
            fm_q[0] <= '0;
            fm_q[1] <= '0;
            fs_q[0] <= 1'b0;
            fs_q[1] <= 1'b0;
            state_q <= S_SC_RD;
          end else begin
            state_q <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            fm_q[uv_q] <= div_rsp.quot;
            fs_q[uv_q] <= dsel[DW] ^ dz[DW];
            uv_q       <= !uv_q;
            state_q    <= uv_q ? S_SC_RD : S_DIVS;
          end
        end
        S_SC_RD: begin
          state_q <= sc_end ? S_FIN : S_SC_CMP;
        end
        S_SC_CMP: begin
          if (sc_skip) begin
            i_q     <= is_left ? i_q + 1'b1 : i_q - 1'b1;
            state_q <= S_SC_RD;
          end else if (!sc_emit) begin
            state_q <= S_FIN;
          end else if (!st_v_q || push_ok) begin
            st_h_q  <= h;
            offm_q  <= off_mag;
            offs_q  <= off[DW];
            uv_q    <= 1'b0;
            state_q <= S_M0;
          end
        end
        S_M0: begin
          acc_q   <= AW'(mul_p);
          state_q <= S_M1;
        end
        S_M1: begin
          acc_q   <= acc_q + (AW'(mul_p) << FLO);
          state_q <= S_M2;
        end
        S_M2: begin
          if (!uv_q) begin
            st_tu_q <= tex_val;
            uv_q    <= 1'b1;
            state_q <= S_M0;
          end else begin
            st_tv_q <= tex_val;
            st_v_q  <= 1'b1;
            n_q     <= n_q + 1'b1;
            if (n_q == NW'(RESULT_LIMIT - 1)) begin
              state_q <= S_FIN;
            end else begin
              i_q     <= is_left ? i_q + 1'b1 : i_q - 1'b1;
              state_q <= S_SC_RD;
            end
          end
        end
        S_FIN: begin
          if (!st_v_q || push_ok) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_v_q;
  assign out_o.split_height = o_h_q;
  assign out_o.tex_u        = o_tu_q;
  assign out_o.tex_v        = o_tv_q;
  assign out_o.ceil_dist    = o_cd_q;
  assign out_o.floor_dist   = o_fd_q;
  assign out_o.out_x        = o_x_q;
  assign out_o.out_y        = o_y_q;
  assign out_o.last         = out_last_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_HEIGHTS))
    else $error("height count above capacity");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.func == FUNC_CLEAR) |=> count_q == '0)
    else $error("clear did not empty the list");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (count_q == $past(count_q) || count_q == '0 ||
                       count_q == $past(count_q) + 1'b1))
    else $error("height count jumped");

  a_write_insert_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SH_RD || state_q == S_SH_WR))
    else $error("list written outside insert");

  a_no_stage_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SC_CMP && sc_emit && st_v_q && !push_ok) |=> state_q == S_SC_CMP)
    else $error("scan advanced over a held vertex");

endmodule
